>>> rtl/matrix_double_centering_macros.svh
// assertion macros shared by the matrix double centering rtl
`ifndef MATRIX_DOUBLE_CENTERING_MACROS_SVH
`define MATRIX_DOUBLE_CENTERING_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define MDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define MDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mdc_pkg.sv
// shared widths, depths and codes of the matrix double centering block
`default_nettype none

package mdc_pkg;

    localparam int MAX_SIZE    = 64;
    localparam int MIN_SIZE    = 3;
    localparam int IDX_W       = $clog2(MAX_SIZE);
    localparam int ADDR_W      = 2 * IDX_W;
    localparam int STORE_DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int SUMS_AW     = IDX_W + 1;
    localparam int SUMS_DEPTH  = 2 * MAX_SIZE;
    localparam int SIZE_W      = 7;
    localparam int VAL_W       = 32;
    localparam int SUM_W       = VAL_W + IDX_W;
    localparam int TOT_W       = VAL_W + 2 * IDX_W;
    localparam int NSQ_W       = 2 * IDX_W + 1;
    localparam int DIVS_W      = NSQ_W + 1;
    localparam int P1_W        = NSQ_W + 1 + VAL_W;
    localparam int RC_W        = SUM_W + 1;
    localparam int P2_W        = SIZE_W + 1 + RC_W;
    localparam int NUM_W       = P2_W + 1;
    localparam int OUT_W       = 33;
    localparam int DIV_STEPS   = NUM_W / 2;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int IN_DATA_W   = ((2 * IDX_W + VAL_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((OUT_W + 7) / 8) * 8;

    // item kinds on the slave tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // saturation limits of the 33-bit result
    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic [NUM_W-1:0] SAT_POS_MAG =
        {{(NUM_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic [NUM_W-1:0] SAT_NEG_MAG =
        {{(NUM_W-OUT_W){1'b0}}, 1'b1, {(OUT_W-1){1'b0}}};

endpackage

`default_nettype wire

>>> rtl/matrix_double_centering.sv
// top level of the matrix double centering block
`default_nettype none

`include "matrix_double_centering_macros.svh"

// Gower double centering of an n-by-n matrix in signed Q16.16. A load item
// (tuser = 0) writes one entry and updates its row sum, column sum and the
// grand total by the difference to the old entry, so entries may be rewritten
// freely; loads outside the active n-by-n area are dropped without a result.
// A read item (tuser = 1) returns -(n*n*x - n*colsum - n*rowsum + total) /
// (2*n*n), rounded toward zero and saturated to 33 bits; outside the active
// area it returns 0 with the error flag in m_axis_tuser. The matrix and the
// row/column sums sit in two single-write memories with registered reads.
// Items are taken one at a time: an in-range load reads its operands at
// accept, then writes the entry and row sum, then the column sum; an
// in-range read passes four arithmetic stages and the radix-4 divider
// before its result goes on. A finished result waits in its own output
// register, so later items keep flowing while the master side stalls,
// until the next result is ready and waits in S_OUT. After reset and after
// every write of matrix_size the block runs a clearing pass over all 4096
// matrix entries (the 128 sums entries are cleared along with the first of
// them) and holds s_axis_tready low meanwhile. matrix_size is saturated
// to 3..64 when written.
module matrix_double_centering (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // matrix_size register
    input  logic                              i_cfg_wen,
    input  logic [mdc_pkg::SIZE_W-1:0]        i_cfg_wdata,
    // input items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // row_index [5:0], col_index [11:6], entry_value [43:12], zero pad above
    input  logic [mdc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // cmd [0]
    input  logic                              s_axis_tuser,
    // result items
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // centered_value [32:0], zero pad above
    output logic [mdc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // range_error [0]
    output logic                              m_axis_tuser
);
    import mdc_pkg::*;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLR  = 4'd1;
    localparam logic [3:0] S_LD1  = 4'd2;
    localparam logic [3:0] S_LD2  = 4'd3;
    localparam logic [3:0] S_RD1  = 4'd4;
    localparam logic [3:0] S_RD2  = 4'd5;
    localparam logic [3:0] S_RD3  = 4'd6;
    localparam logic [3:0] S_RD4  = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    // control state
    logic [3:0]               r_state, n_state;
    logic [ADDR_W-1:0]        r_clr_addr, n_clr_addr;
    logic signed [TOT_W-1:0]  r_total, n_total;
    logic [SIZE_W-1:0]        r_n;
    logic [NSQ_W-1:0]         r_nsq;
    logic [DIVS_W-1:0]        r_dvs;
    logic                     r_out_valid;

    // payload
    logic [IDX_W-1:0]         r_row, r_col;
    logic signed [VAL_W-1:0]  r_val;
    logic signed [SUM_W-1:0]  r_col_new;
    logic signed [P1_W-1:0]   r_p1;
    logic signed [RC_W-1:0]   r_rc;
    logic signed [P2_W-1:0]   r_p2;
    logic signed [NUM_W-1:0]  r_num;
    logic                     r_neg;
    logic [OUT_W-1:0]         r_res_value;
    logic                     r_res_err;
    logic [OUT_W-1:0]         r_out_value;
    logic                     r_out_err;

    // memories and their registered read data
    logic signed [VAL_W-1:0]  mem_store [STORE_DEPTH];
    logic signed [SUM_W-1:0]  mem_sums  [SUMS_DEPTH];
    logic signed [VAL_W-1:0]  r_store_q;
    logic signed [SUM_W-1:0]  r_row_q, r_col_q;

    // memory write ports
    logic                     w_st_we;
    logic [ADDR_W-1:0]        w_st_wa;
    logic signed [VAL_W-1:0]  w_st_wd;
    logic                     w_sm_we;
    logic [SUMS_AW-1:0]       w_sm_wa;
    logic signed [SUM_W-1:0]  w_sm_wd;

    logic                     w_accept;
    logic [IDX_W-1:0]         w_in_row, w_in_col;
    logic signed [VAL_W-1:0]  w_in_val;
    logic                     w_inside;
    logic [SIZE_W-1:0]        w_cfg_n;
    logic [NSQ_W-1:0]         w_cfg_nsq;
    logic signed [VAL_W:0]    w_delta;
    logic signed [SUM_W-1:0]  w_row_new, w_col_new;
    logic [NUM_W-1:0]         w_mag;
    logic                     w_div_start, w_div_busy, w_div_done;
    logic [NUM_W-1:0]         w_quot;
    logic [OUT_W-1:0]         w_sat;
    logic                     w_out_load;

    // unpack the input item
    assign w_in_row = s_axis_tdata[IDX_W-1:0];
    assign w_in_col = s_axis_tdata[2*IDX_W-1:IDX_W];
    assign w_in_val = s_axis_tdata[2*IDX_W+VAL_W-1:2*IDX_W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign w_inside      = ({1'b0, w_in_row} < r_n) && ({1'b0, w_in_col} < r_n);

    // saturate the written size and precompute n*n and the divisor 2*n*n
    always_comb begin
        priority if (i_cfg_wdata < SIZE_W'(MIN_SIZE)) begin
            w_cfg_n = SIZE_W'(MIN_SIZE);
        end else if (i_cfg_wdata > SIZE_W'(MAX_SIZE)) begin
            w_cfg_n = SIZE_W'(MAX_SIZE);
        end else begin
            w_cfg_n = i_cfg_wdata;
        end
    end
    assign w_cfg_nsq = NSQ_W'(w_cfg_n) * NSQ_W'(w_cfg_n);

    // load update: difference against the old entry, applied to both sums
    assign w_delta   = {r_val[VAL_W-1], r_val} - {r_store_q[VAL_W-1], r_store_q};
    assign w_row_new = r_row_q + {{(SUM_W-VAL_W-1){w_delta[VAL_W]}}, w_delta};
    assign w_col_new = r_col_q + {{(SUM_W-VAL_W-1){w_delta[VAL_W]}}, w_delta};

    // magnitude of the numerator for the unsigned divider
    assign w_mag = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);

    // negate the truncated quotient and clamp to 33 bits
    always_comb begin
        if (r_neg) begin
            w_sat = (w_quot > SAT_POS_MAG) ? OUT_MAX : w_quot[OUT_W-1:0];
        end else begin
            w_sat = (w_quot > SAT_NEG_MAG) ? OUT_MIN : -w_quot[OUT_W-1:0];
        end
    end

    // sequencer and memory write control
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_total     = r_total;
        w_div_start = 1'b0;
        w_st_we     = 1'b0;
        w_st_wa     = {r_row, r_col};
        w_st_wd     = r_val;
        w_sm_we     = 1'b0;
        w_sm_wa     = {1'b0, r_row};
        w_sm_wd     = w_row_new;
        unique case (r_state)
            S_CLR: begin
                // one matrix entry per cycle, sums ride along in the first rows
                w_st_we    = 1'b1;
                w_st_wa    = r_clr_addr;
                w_st_wd    = '0;
                w_sm_we    = (r_clr_addr < ADDR_W'(SUMS_DEPTH));
                w_sm_wa    = r_clr_addr[SUMS_AW-1:0];
                w_sm_wd    = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (s_axis_tuser == CMD_LOAD) begin
                        n_state = w_inside ? S_LD1 : S_IDLE;
                    end else begin
                        n_state = w_inside ? S_RD1 : S_OUT;
                    end
                end
            end
            S_LD1: begin
                // entry and row sum now, column sum next cycle
                w_st_we = 1'b1;
                w_sm_we = 1'b1;
                n_total = r_total + {{(TOT_W-VAL_W-1){w_delta[VAL_W]}}, w_delta};
                n_state = S_LD2;
            end
            S_LD2: begin
                w_sm_we = 1'b1;
                w_sm_wa = {1'b1, r_col};
                w_sm_wd = r_col_new;
                n_state = S_IDLE;
            end
            S_RD1: n_state = S_RD2;
            S_RD2: n_state = S_RD3;
            S_RD3: n_state = S_RD4;
            S_RD4: begin
                w_div_start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // a size write wipes the matrix and all sums
        if (i_cfg_wen) begin
            n_state    = S_CLR;
            n_clr_addr = '0;
            n_total    = '0;
        end
    end

    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_total     <= '0;
            r_n         <= SIZE_W'(MAX_SIZE);
            r_nsq       <= NSQ_W'(MAX_SIZE * MAX_SIZE);
            r_dvs       <= DIVS_W'(2 * MAX_SIZE * MAX_SIZE);
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_total    <= n_total;
            if (i_cfg_wen) begin
                r_n   <= w_cfg_n;
                r_nsq <= w_cfg_nsq;
                r_dvs <= {w_cfg_nsq, 1'b0};
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_row       <= w_in_row;
            r_col       <= w_in_col;
            r_val       <= w_in_val;
            r_res_value <= '0;
            r_res_err   <= !w_inside;
        end
        if (r_state == S_LD1) begin
            r_col_new <= w_col_new;
        end
        if (r_state == S_RD1) begin
            r_p1 <= $signed({1'b0, r_nsq}) * r_store_q;
            r_rc <= {r_row_q[SUM_W-1], r_row_q} + {r_col_q[SUM_W-1], r_col_q};
        end
        if (r_state == S_RD2) begin
            r_p2 <= $signed({1'b0, r_n}) * r_rc;
        end
        if (r_state == S_RD3) begin
            r_num <= r_p1 - r_p2 + r_total;
        end
        if (r_state == S_RD4) begin
            r_neg <= r_num[NUM_W-1];
        end
        if ((r_state == S_DIV) && w_div_done) begin
            r_res_value <= w_sat;
            r_res_err   <= 1'b0;
        end
        if (w_out_load) begin
            r_out_value <= r_res_value;
            r_out_err   <= r_res_err;
        end
    end

    // matrix memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_st_we) begin
            mem_store[w_st_wa] <= w_st_wd;
        end
        if (w_accept) begin
            r_store_q <= mem_store[{w_in_row, w_in_col}];
        end
    end

    // sums memory: rows in the lower half, columns in the upper half
    always_ff @(posedge i_clk) begin
        if (w_sm_we) begin
            mem_sums[w_sm_wa] <= w_sm_wd;
        end
        if (w_accept) begin
            r_row_q <= mem_sums[{1'b0, w_in_row}];
            r_col_q <= mem_sums[{1'b1, w_in_col}];
        end
    end

    mdc_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_mag),
        .i_divisor  (r_dvs),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-OUT_W){1'b0}}, r_out_value};
    assign m_axis_tuser  = r_out_err;

    // size write always restarts the clearing pass from the first entry
    `MDC_ASSERT_NEXT(a_cfg_restarts_clear, i_cfg_wen, (r_state == S_CLR) && (r_clr_addr == '0), "size write did not restart the clearing pass")
    // a pending result is never overwritten while the master stalls
    `MDC_ASSERT_NEXT(a_out_holds, (r_state == S_OUT) && r_out_valid && !m_axis_tready && !i_cfg_wen, r_state == S_OUT, "result left its state while output register was full")
    // out-of-range reads carry a zero value
    `MDC_ASSERT_NOW(a_err_zero, r_out_valid && r_out_err, r_out_value == '0, "range error result with nonzero value")
    // a new division never starts on top of a running one
    `MDC_ASSERT_NOW(a_div_free, r_state == S_RD4, !w_div_busy, "divider still busy when a read reached it")

endmodule

`default_nettype wire

>>> rtl/mdc_divider.sv
// unsigned radix-4 restoring divider, two quotient bits per cycle
`default_nettype none

module mdc_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [mdc_pkg::NUM_W-1:0]    i_dividend,
    input  logic [mdc_pkg::DIVS_W-1:0]   i_divisor,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [mdc_pkg::NUM_W-1:0]    o_quot
);
    import mdc_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0]     r_dvd;
    logic [DIVS_W-1:0]    r_rem;
    logic [DIVS_W-1:0]    r_dvs;

    logic [DIVS_W:0]      w_t1, w_d1, w_t2, w_d2;
    logic                 w_ge1, w_ge2;
    logic [DIVS_W-1:0]    w_rem1, w_rem2;

    // two dependent shift-subtract steps
    always_comb begin
        w_t1   = {r_rem, r_dvd[NUM_W-1]};
        w_d1   = w_t1 - {1'b0, r_dvs};
        w_ge1  = (w_t1 >= {1'b0, r_dvs});
        w_rem1 = w_ge1 ? w_d1[DIVS_W-1:0] : w_t1[DIVS_W-1:0];
        w_t2   = {w_rem1, r_dvd[NUM_W-2]};
        w_d2   = w_t2 - {1'b0, r_dvs};
        w_ge2  = (w_t2 >= {1'b0, r_dvs});
        w_rem2 = w_ge2 ? w_d2[DIVS_W-1:0] : w_t2[DIVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out at the top while quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[NUM_W-3:0], w_ge1, w_ge2};
            r_rem <= w_rem2;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_dvd;

endmodule

`default_nettype wire

>>> tb/mdc_checker.sv
// checker for the matrix double centering block: tracks the matrix and sums, compares results
module mdc_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wen,
    input  logic [mdc_pkg::SIZE_W-1:0]     i_cfg_wdata,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [mdc_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic                           i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [mdc_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input  logic                           i_m_tuser,
    input  logic                           i_final,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mdc_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0] centered_value;
        logic             range_error;
    } centered_t;

    localparam longint CENTER_MAX = 64'sd4294967295;
    localparam longint CENTER_MIN = -64'sd4294967296;

    logic signed [VAL_W-1:0] entry_mem [STORE_DEPTH];
    logic signed [SUM_W-1:0] row_acc [MAX_SIZE];
    logic signed [SUM_W-1:0] col_acc [MAX_SIZE];
    logic signed [TOT_W-1:0] total_acc;
    logic [SIZE_W-1:0]       size_reg;
    centered_t               centered_q [$];
    int                      mismatch_count = 0;

    initial o_fail_count = 0;
    initial o_pending = 0;

    function automatic int unsigned active_size(input logic [SIZE_W-1:0] s);
        if (s < MIN_SIZE) return MIN_SIZE;
        if (s > MAX_SIZE) return MAX_SIZE;
        return s;
    endfunction

    task automatic clear_matrix();
        for (int i = 0; i < STORE_DEPTH; i++) entry_mem[i] = '0;
        for (int i = 0; i < MAX_SIZE; i++) begin
            row_acc[i] = '0;
            col_acc[i] = '0;
        end
        total_acc = '0;
    endtask

    // one accepted item: a load updates the entry and the sums, a read queues its result
    task automatic apply_item(input logic cmd, input logic [IDX_W-1:0] r,
                              input logic [IDX_W-1:0] c, input logic signed [VAL_W-1:0] v);
        int unsigned n;
        logic signed [VAL_W:0] delta;
        longint nn, x, num, q, res;
        centered_t e;
        n = active_size(size_reg);
        if (cmd == CMD_LOAD) begin
            if (r < n && c < n) begin
                delta = v - entry_mem[{r, c}];
                entry_mem[{r, c}] = v;
                row_acc[r] += delta;
                col_acc[c] += delta;
                total_acc += delta;
            end
        end else begin
            if (!(r < n && c < n)) begin
                e.centered_value = '0;
                e.range_error = 1'b1;
            end else begin
                nn = n;
                x = entry_mem[{r, c}];
                num = nn * nn * x - nn * col_acc[c] - nn * row_acc[r] + total_acc;
                q = num / (2 * nn * nn);
                res = -q;
                if (res > CENTER_MAX) res = CENTER_MAX;
                if (res < CENTER_MIN) res = CENTER_MIN;
                e.centered_value = res[OUT_W-1:0];
                e.range_error = 1'b0;
            end
            centered_q.push_back(e);
        end
    endtask

    always @(posedge i_clk) begin : watch
        centered_t want;
        if (!i_rst_n) begin
            size_reg = 7'd64;
            clear_matrix();
            centered_q.delete();
        end else begin
            if (i_cfg_wen) begin
                size_reg = i_cfg_wdata;
                clear_matrix();
            end
            // results first: nothing accepted at this edge can already have its result here
            if (i_m_tvalid && i_m_tready) begin
                if (centered_q.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("%0t: result with nothing pending: value %h err %b",
                                 $realtime, i_m_tdata[OUT_W-1:0], i_m_tuser);
                    mismatch_count++;
                end else begin
                    want = centered_q.pop_front();
                    if (i_m_tdata[OUT_W-1:0] !== want.centered_value ||
                        i_m_tuser !== want.range_error) begin
                        if (mismatch_count < 10)
                            $display("%0t: mismatch: value exp %h got %h, err exp %b got %b",
                                     $realtime, want.centered_value, i_m_tdata[OUT_W-1:0],
                                     want.range_error, i_m_tuser);
                        mismatch_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                apply_item(i_s_tuser, i_s_tdata[IDX_W-1:0], i_s_tdata[2*IDX_W-1:IDX_W],
                           i_s_tdata[2*IDX_W+VAL_W-1:2*IDX_W]);
        end
        o_pending <= centered_q.size();
        o_fail_count <= mismatch_count + (i_final ? centered_q.size() : 0);
    end

endmodule

>>> tb/tb_matrix_double_centering.sv
// testbench top for the matrix double centering block: stimulus, stalls and verdict
module tb_matrix_double_centering;
    timeunit 1ns;
    timeprecision 1ps;

    import mdc_pkg::*;

    // cycles with no item moving on either side before the run is abandoned;
    // the clearing pass after reset or a size write also counts as idle
    localparam int IDLE_LIMIT = 20000;
    // cycles to let an in-flight load finish before touching the size register
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASE_ITEMS = 204;

    localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

    // receiver behavior, switched at random
    typedef enum int {RX_OPEN, RX_CHOPPY, RX_HOLD} rx_mode_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wen = 1'b0;
    logic [SIZE_W-1:0]     i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    logic final_check = 1'b0;
    int   fail_count;
    int   pending;

    // sender burst bookkeeping
    int burst_left = 0;
    // effective size as the block sees it
    int n_active = MAX_SIZE;
    // recently loaded coordinates, so reads often hit written entries
    logic [IDX_W-1:0] recent_row [16];
    logic [IDX_W-1:0] recent_col [16];
    int recent_cnt = 0;
    int recent_wr = 0;

    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    matrix_double_centering uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    mdc_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_final      (final_check),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver: open stretches, choppy stretches and hard stalls
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 40) : $urandom_range(10, 120);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN: begin
                m_axis_tready <= 1'b1;
            end
            RX_CHOPPY: begin
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                m_axis_tready <= 1'b0;
            end
        endcase
    end

    // watchdog: ends the run when nothing moves for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    function automatic int size_in_use(input logic [SIZE_W-1:0] s);
        if (s < MIN_SIZE) return MIN_SIZE;
        if (s > MAX_SIZE) return MAX_SIZE;
        return s;
    endfunction

    // entry values: extremes and small values show up often, the rest is raw random
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return VAL_W'(int'($urandom_range(0, 131071)) - 65536);
            default: return $urandom;
        endcase
    endfunction

    // one item through the slave side; gaps come only between bursts
    task automatic send_item(input logic cmd, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {{(IN_DATA_W - 2 * IDX_W - VAL_W){1'b0}}, value, col, row};
        do @(posedge i_clk); while (!s_axis_tready);
        if (cmd == CMD_LOAD && row < n_active && col < n_active) begin
            recent_row[recent_wr] = row;
            recent_col[recent_wr] = col;
            recent_wr = (recent_wr + 1) % 16;
            if (recent_cnt < 16) recent_cnt++;
        end
    endtask

    // sender goes quiet until every pending result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // size register write, only with the block idle; it clears the matrix and sums
    task automatic write_size(input logic [SIZE_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        n_active = size_in_use(value);
        recent_cnt = 0;
        recent_wr = 0;
    endtask

    // random traffic: mostly in-range loads and reads, some out-of-range probes
    task automatic run_phase(input int count);
        logic             cmd;
        logic [IDX_W-1:0] row, col;
        int               k;
        for (int i = 0; i < count; i++) begin
            // pressure point halfway through: let the pipeline empty out
            if (i == count / 2) drain_results();
            cmd = ($urandom_range(0, 99) < 55) ? CMD_LOAD : CMD_READ;
            if (n_active < MAX_SIZE && $urandom_range(0, 9) == 0) begin
                // at least one coordinate beyond the active area
                case ($urandom_range(0, 2))
                    0: begin
                        row = $urandom_range(n_active, MAX_SIZE - 1);
                        col = $urandom_range(0, MAX_SIZE - 1);
                    end
                    1: begin
                        row = $urandom_range(0, MAX_SIZE - 1);
                        col = $urandom_range(n_active, MAX_SIZE - 1);
                    end
                    default: begin
                        row = $urandom_range(n_active, MAX_SIZE - 1);
                        col = $urandom_range(n_active, MAX_SIZE - 1);
                    end
                endcase
            end else if (cmd == CMD_READ && recent_cnt > 0 && $urandom_range(0, 1) == 0) begin
                k = $urandom_range(0, recent_cnt - 1);
                row = recent_row[k];
                col = recent_col[k];
            end else begin
                row = $urandom_range(0, n_active - 1);
                col = $urandom_range(0, n_active - 1);
            end
            send_item(cmd, row, col, (cmd == CMD_LOAD) ? pick_value() : $urandom);
        end
    endtask

    initial begin : stimulus
        logic [SIZE_W-1:0] sizes [8];
        sizes = '{7'd127, 7'd0, 7'd5, 7'd64, 7'd2, 7'd17, 7'd100, 7'd3};
        sizes[2] = $urandom_range(4, 12);
        sizes[5] = $urandom_range(13, 63);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset size of 64: empty read, extremes in the corners, rewrite of an entry
        send_item(CMD_READ, 6'd0, 6'd0, 32'h0);
        send_item(CMD_LOAD, 6'd0, 6'd0, VAL_MAX);
        send_item(CMD_LOAD, 6'd63, 6'd63, VAL_MIN);
        send_item(CMD_READ, 6'd0, 6'd0, 32'hFFFF_FFFF);
        send_item(CMD_READ, 6'd63, 6'd63, 32'h0);
        send_item(CMD_LOAD, 6'd0, 6'd0, 32'h0001_0000);
        send_item(CMD_READ, 6'd0, 6'd0, 32'h0);

        // smallest size: the write clears what was loaded before
        write_size(7'd3);
        send_item(CMD_READ, 6'd0, 6'd0, 32'h0);
        // loads beyond the active area are dropped
        send_item(CMD_LOAD, 6'd3, 6'd0, VAL_MAX);
        send_item(CMD_LOAD, 6'd0, 6'd3, VAL_MIN);
        // reads beyond the active area give zero with the error flag
        send_item(CMD_READ, 6'd3, 6'd0, 32'h0);
        send_item(CMD_READ, 6'd0, 6'd63, 32'h0);
        send_item(CMD_READ, 6'd63, 6'd63, 32'h0);
        // extreme pattern over the full 3x3 area to push the result toward its limits
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                send_item(CMD_LOAD, r[IDX_W-1:0], c[IDX_W-1:0],
                          (r == 0 && c == 0) ? VAL_MAX : ((r == 0 || c == 0) ? VAL_MIN
                                                                            : VAL_MAX));
        send_item(CMD_READ, 6'd0, 6'd0, 32'h0);
        send_item(CMD_READ, 6'd1, 6'd1, 32'h0);
        send_item(CMD_READ, 6'd2, 6'd1, 32'h0);

        // random part over several sizes, saturating values among them
        foreach (sizes[p]) begin
            write_size(sizes[p]);
            run_phase(PHASE_ITEMS);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        final_check <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
